### rtl/ppq_pkg.sv
// Package for the payload packet queue: status and operation codes, default sizes
// and the command struct passed from the controller to the datapath.
// No dependencies.
package ppq_pkg;

	localparam int DefQueueSlots = 4;
	localparam int DefSlotBytes  = 64;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_LONG    = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_PENDING = 3'd4;

	typedef struct packed {
		logic exec;
		logic load;
	} cmd_t;

endpackage

### rtl/ppq_in_if.sv
// Input channel of the payload packet queue: valid/ready plus one operation.
// Depends on nothing but the field widths of the queue.
interface ppq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [5:0] read_index;

	modport source (output valid, op, data_byte, last_byte, read_index, input ready);
	modport sink (input valid, op, data_byte, last_byte, read_index, output ready);
endinterface

### rtl/ppq_out_if.sv
// Result channel of the payload packet queue: valid/ready plus one result.
// Depends on nothing but the field widths of the queue.
interface ppq_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] read_data;
	logic [6:0] head_length;
	logic [2:0] entries_used;

	modport source (output valid, status, read_data, head_length, entries_used, input ready);
	modport sink (input valid, status, read_data, head_length, entries_used, output ready);
endinterface

### rtl/ppq_ctrl.sv
// Controller of the payload packet queue: input/output handshakes and the two-state
// sequencer that issues execute and load commands. Depends on ppq_pkg.
module ppq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ppq_pkg::cmd_t cmd
);
	import ppq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.exec  = (state_q == ST_IDLE) && in_valid;
	assign cmd.load  = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.exec) state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (cmd.load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/ppq_datapath.sv
// Datapath of the payload packet queue: ring pointers, staging state, the payload
// and length memories and the result register. Depends on ppq_pkg.
module ppq_datapath #(
	parameter int QUEUE_SLOTS = ppq_pkg::DefQueueSlots,
	parameter int SLOT_BYTES  = ppq_pkg::DefSlotBytes
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ppq_pkg::cmd_t cmd,
	input  logic [1:0]    op,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic [5:0]    read_index,
	output logic [2:0]    status,
	output logic [7:0]    read_data,
	output logic [6:0]    head_length,
	output logic [2:0]    entries_used
);
	import ppq_pkg::*;

	localparam int SW = $clog2(QUEUE_SLOTS);
	localparam int UW = $clog2(QUEUE_SLOTS + 1);
	localparam int LW = $clog2(SLOT_BYTES + 1);
	localparam int OW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int DEPTH = QUEUE_SLOTS * SLOT_BYTES;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [SW-1:0] wr_slot_q, rd_slot_q, wr_slot_d, rd_slot_d;
	logic [UW-1:0] used_q, used_d;
	logic [LW-1:0] stage_q, stage_d;
	logic          full_q, full_d, over_q, over_d;

	logic [7:0]    pmem [DEPTH];
	logic [LW-1:0] lmem [QUEUE_SLOTS];

	logic          p_wr, p_rd, l_wr;
	logic [AW-1:0] p_waddr, p_raddr;
	logic [OW-1:0] wr_off, rd_off;
	logic [2:0]    status_d;

	logic [7:0]    mem_rdata_s1;
	logic          rd_hit_s1;
	logic [2:0]    status_s1;
	logic [LW-1:0] head_len_q;

	logic [2:0]    status_q, entries_used_q;
	logic [7:0]    read_data_q;
	logic [6:0]    head_length_q;

	logic          first, full_now, store;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		next_slot = (32'(s) == QUEUE_SLOTS - 1) ? '0 : s + 1'b1;
	endfunction

	assign wr_off  = OW'(stage_q);
	assign rd_off  = OW'(read_index);
	assign p_waddr = AW'(32'(wr_slot_q) * SLOT_BYTES + 32'(wr_off));
	assign p_raddr = AW'(32'(rd_slot_q) * SLOT_BYTES + 32'(rd_off));

	always_comb begin
		wr_slot_d = wr_slot_q;
		rd_slot_d = rd_slot_q;
		used_d    = used_q;
		stage_d   = stage_q;
		full_d    = full_q;
		over_d    = over_q;
		status_d  = ST_OK;
		p_wr      = 1'b0;
		p_rd      = 1'b0;
		l_wr      = 1'b0;
		store     = 1'b0;
		first     = (stage_q == '0) && !full_q && !over_q;
		full_now  = full_q || (first && 32'(used_q) == QUEUE_SLOTS);
		case (op)
			OP_PUSH: begin
				if (full_now) begin
					status_d = ST_FULL;
					full_d   = !last_byte;
					stage_d  = '0;
				end else begin
					store  = !over_q && 32'(stage_q) < SLOT_BYTES;
					over_d = over_q || !store;
					p_wr   = store;
					if (store) stage_d = stage_q + 1'b1;
					if (!last_byte) begin
						status_d = ST_PENDING;
					end else begin
						if (over_d) begin
							status_d = ST_LONG;
						end else begin
							status_d  = ST_OK;
							l_wr      = 1'b1;
							wr_slot_d = next_slot(wr_slot_q);
							used_d    = used_q + 1'b1;
						end
						over_d  = 1'b0;
						stage_d = '0;
					end
				end
			end
			OP_READ: begin
				if (used_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					p_rd = 32'(read_index) < 32'(head_len_q) && 32'(read_index) < SLOT_BYTES;
				end
			end
			OP_RELEASE: begin
				if (used_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					rd_slot_d = next_slot(rd_slot_q);
					used_d    = used_q - 1'b1;
				end
			end
			default: status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			used_q    <= '0;
			stage_q   <= '0;
			full_q    <= 1'b0;
			over_q    <= 1'b0;
		end else if (cmd.exec) begin
			wr_slot_q <= wr_slot_d;
			rd_slot_q <= rd_slot_d;
			used_q    <= used_d;
			stage_q   <= stage_d;
			full_q    <= full_d;
			over_q    <= over_d;
		end
	end

	// Payload memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.exec && p_wr) pmem[p_waddr] <= data_byte;
		if (cmd.exec && p_rd) mem_rdata_s1 <= pmem[p_raddr];
	end

	// Length memory, read at the head after this operation. A commit into the slot
	// that becomes the head in the same beat is forwarded around the memory.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (l_wr) lmem[wr_slot_q] <= stage_d == '0 ? stage_q + LW'(store) : stage_d;
			if (l_wr && wr_slot_q == rd_slot_d) begin
				head_len_q <= stage_q + LW'(store);
			end else begin
				head_len_q <= lmem[rd_slot_d];
			end
			status_s1 <= status_d;
			rd_hit_s1 <= p_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q       <= status_s1;
			read_data_q    <= rd_hit_s1 ? mem_rdata_s1 : 8'd0;
			head_length_q  <= (used_q != '0) ? 7'(head_len_q) : 7'd0;
			entries_used_q <= 3'(used_q);
		end
	end

	assign status       = status_q;
	assign read_data    = read_data_q;
	assign head_length  = head_length_q;
	assign entries_used = entries_used_q;

endmodule

### rtl/payload_packet_queue.sv
// Top level of the payload packet queue: a ring of payload slots fed one byte a beat.
// Depends on ppq_pkg, ppq_in_if, ppq_out_if, ppq_ctrl and ppq_datapath.
//
//   channel  | role   | beat carries
//   ---------+--------+--------------------------------------------------
//   in       | sink   | op, data_byte, last_byte, read_index
//   out      | source | status, read_data, head_length, entries_used
//
// For each item, the accepting edge updates the queue state and starts the registered
// payload and length memory reads; the result is then loaded once the output
// register is empty or out.ready is high. One item is in flight at a time; the input
// is not ready until its result has moved into the output register, which holds while
// out.ready is low. Reset is asynchronous and clears pointers, counts and flags;
// payload memory is not cleared, as only bytes that were written are ever read.
module payload_packet_queue #(
	parameter int QUEUE_SLOTS = ppq_pkg::DefQueueSlots,
	parameter int SLOT_BYTES  = ppq_pkg::DefSlotBytes
) (
	input logic      clk,
	input logic      arst_n,
	ppq_in_if.sink   in,
	ppq_out_if.source out
);
	import ppq_pkg::*;

	cmd_t cmd;

	ppq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.cmd       (cmd)
	);

	ppq_datapath #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.SLOT_BYTES  (SLOT_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (in.op),
		.data_byte    (in.data_byte),
		.last_byte    (in.last_byte),
		.read_index   (in.read_index),
		.status       (out.status),
		.read_data    (out.read_data),
		.head_length  (out.head_length),
		.entries_used (out.entries_used)
	);

endmodule
